[sv/tfca_pkg.sv]
`default_nettype none
package tfca_pkg;

   localparam int SENSOR_WIDTH  = 32;
   localparam int SENSOR_HEIGHT = 24;
   localparam int FRAME_PIXELS  = SENSOR_WIDTH * SENSOR_HEIGHT;
   localparam int COUNT_W       = $clog2(FRAME_PIXELS + 1);

   localparam int TEMP_W     = 16;
   localparam int COLOUR_W   = 24;
   localparam int CHAN_W     = 8;
   localparam int CHANNELS   = 3;
   localparam int ENTRIES    = 5;
   localparam int ENTRY_W    = $clog2(ENTRIES);
   localparam int CSR_IDX_W  = 3;

   // position along the palette: 2 entry bits, 8 fraction bits
   localparam int FRAC_W     = 8;
   localparam int QUO_W      = 10;
   localparam int DIV_STEPS  = QUO_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] REG_FIRST_MAX = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_MIN = 3'd6;

   localparam logic [ENTRY_W-1:0] ENTRY_BOTTOM = 3'd0;
   localparam logic [ENTRY_W-1:0] ENTRY_TOP    = 3'd4;

   localparam logic [TEMP_W-1:0] FIRST_MAX_RESET = 16'd800;
   localparam logic [TEMP_W-1:0] FIRST_MIN_RESET = 16'd0;
   localparam logic [TEMP_W-1:0] RUN_MAX_RESET   = 16'h8000;
   localparam logic [TEMP_W-1:0] RUN_MIN_RESET   = 16'h7fff;

   localparam logic [COLOUR_W-1:0] PALETTE_RESET [ENTRIES] = '{
      24'h000000, 24'h20008c, 24'hcc0077, 24'hffdd00, 24'hffffff
   };

endpackage
`default_nettype wire

[sv/tfca_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle; dividend < divisor
module tfca_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [tfca_pkg::TEMP_W-1:0]          dividend,
   input  wire logic [tfca_pkg::TEMP_W-1:0]          divisor,
   output logic                                      done,
   output logic [tfca_pkg::QUO_W-1:0]                quotient
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [tfca_pkg::DIV_CNT_W-1:0]      cnt_ff;
   logic [tfca_pkg::TEMP_W:0]           rem_ff;
   logic [tfca_pkg::TEMP_W:0]           rem_in;
   logic [tfca_pkg::TEMP_W-1:0]         dsr_ff;
   logic [tfca_pkg::QUO_W-1:0]          quo_ff;
   logic [tfca_pkg::TEMP_W:0]           shifted;
   logic                                ge;

   always_comb begin
      shifted = {rem_ff[tfca_pkg::TEMP_W-1:0], 1'b0};
      ge      = shifted >= {1'b0, dsr_ff};
      rem_in  = ge ? shifted - {1'b0, dsr_ff} : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == tfca_pkg::DIV_CNT_W'(tfca_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend};
         dsr_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[tfca_pkg::QUO_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[sv/tfca_lerp.sv]
`default_nettype none
// one channel: lo + floor((hi - lo) * f / 256)
module tfca_lerp (
   input  wire logic [tfca_pkg::CHAN_W-1:0] lo,
   input  wire logic [tfca_pkg::CHAN_W-1:0] hi,
   input  wire logic [tfca_pkg::FRAC_W-1:0] frac,
   output logic      [tfca_pkg::CHAN_W-1:0] result
);

   logic signed [tfca_pkg::CHAN_W:0]       diff;
   logic signed [2*tfca_pkg::CHAN_W+1:0]   prod;
   logic signed [2*tfca_pkg::CHAN_W+1:0]   prod_sh;
   logic signed [tfca_pkg::CHAN_W+1:0]     sum;

   always_comb begin
      diff    = $signed({1'b0, hi}) - $signed({1'b0, lo});
      prod    = diff * $signed({1'b0, frac});
      prod_sh = prod >>> tfca_pkg::FRAC_W;
      sum     = $signed({2'b00, lo}) + prod_sh[tfca_pkg::CHAN_W+1:0];
      result  = sum[tfca_pkg::CHAN_W-1:0];
   end

endmodule
`default_nettype wire

[sv/thermal_false_color_autorange_core.sv]
`default_nettype none
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/tready    | tdata[15:0] temperature
// rsp     | out       | rsp_tvalid/tready    | tdata red, green, blue; tlast frame_end
// csr     | in        | csr_tvalid/tready    | csr_index, csr_data
//
// One item at a time. An item inside the range goes through the serial
// divider, which gives one bit of the palette position per cycle, then two
// palette fetches and one blend step per colour channel on the shared
// multiplier. Items at or beyond the range ends skip the divider.
// A finished result waits in the output register; the next item is taken
// meanwhile. Reset is synchronous; csr is always ready.
module thermal_false_color_autorange_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] temperature
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   output logic             rsp_tlast,
   input  wire logic        csr_tvalid,
   output logic             csr_tready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_FETCH_LO, S_FETCH_HI, S_MIX, S_SEND
   } state_type;

   state_type                           state_ff;
   logic [tfca_pkg::COLOUR_W-1:0]       palette_ff [tfca_pkg::ENTRIES];
   logic [tfca_pkg::TEMP_W-1:0]         act_max_ff;
   logic [tfca_pkg::TEMP_W-1:0]         act_min_ff;
   logic [tfca_pkg::TEMP_W-1:0]         run_max_ff;
   logic [tfca_pkg::TEMP_W-1:0]         run_min_ff;
   logic [tfca_pkg::TEMP_W-1:0]         run_max_in;
   logic [tfca_pkg::TEMP_W-1:0]         run_min_in;
   logic [tfca_pkg::COUNT_W-1:0]        count_ff;
   logic                                frame_done_ff;
   logic                                last_ff;
   logic [tfca_pkg::ENTRY_W-1:0]        lo_idx_ff;
   logic [tfca_pkg::ENTRY_W-1:0]        hi_idx_ff;
   logic [tfca_pkg::FRAC_W-1:0]         frac_ff;
   logic [tfca_pkg::COLOUR_W-1:0]       lo_col_ff;
   logic [tfca_pkg::COLOUR_W-1:0]       hi_col_ff;
   logic [1:0]                          ch_ff;
   logic [tfca_pkg::CHAN_W-1:0]         col_ff [tfca_pkg::CHANNELS];
   logic                                rsp_valid_ff;
   logic [tfca_pkg::COLOUR_W-1:0]       rsp_data_ff;
   logic                                rsp_last_ff;

   logic                                accept;
   logic                                last;
   logic signed [tfca_pkg::TEMP_W-1:0]  temp;
   logic signed [tfca_pkg::TEMP_W:0]    d_w;
   logic signed [tfca_pkg::TEMP_W:0]    r_w;
   logic                                r_pos;
   logic                                d_pos;
   logic                                d_ge_r;
   logic                                need_div;
   logic [tfca_pkg::ENTRY_W-1:0]        direct_idx;
   logic                                div_done;
   logic [tfca_pkg::QUO_W-1:0]          quotient;
   logic [tfca_pkg::ENTRY_W-1:0]        div_lo;
   logic [tfca_pkg::CHAN_W-1:0]         lo_byte;
   logic [tfca_pkg::CHAN_W-1:0]         hi_byte;
   logic [tfca_pkg::CHAN_W-1:0]         blend;
   logic                                send_go;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_tready = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign send_go    = (state_ff == S_SEND) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      temp     = $signed(req_tdata);
      d_w      = $signed({temp[tfca_pkg::TEMP_W-1], temp})
               - $signed({act_min_ff[tfca_pkg::TEMP_W-1], act_min_ff});
      r_w      = $signed({act_max_ff[tfca_pkg::TEMP_W-1], act_max_ff})
               - $signed({act_min_ff[tfca_pkg::TEMP_W-1], act_min_ff});
      r_pos    = !r_w[tfca_pkg::TEMP_W] && (r_w != '0);
      d_pos    = !d_w[tfca_pkg::TEMP_W] && (d_w != '0);
      d_ge_r   = d_w >= r_w;
      need_div = r_pos && d_pos && !d_ge_r;
      if (!r_pos) begin
         direct_idx = d_pos ? tfca_pkg::ENTRY_TOP : tfca_pkg::ENTRY_BOTTOM;
      end else if (!d_pos) begin
         direct_idx = tfca_pkg::ENTRY_BOTTOM;
      end else begin
         direct_idx = tfca_pkg::ENTRY_TOP;
      end
      run_max_in = ($signed(req_tdata) > $signed(run_max_ff)) ? req_tdata : run_max_ff;
      run_min_in = ($signed(req_tdata) < $signed(run_min_ff)) ? req_tdata : run_min_ff;
      last       = (count_ff == tfca_pkg::COUNT_W'(tfca_pkg::FRAME_PIXELS - 1));
      div_lo     = {1'b0, quotient[tfca_pkg::QUO_W-1 -: 2]};
   end

   tfca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && need_div),
      .dividend (d_w[tfca_pkg::TEMP_W-1:0]),
      .divisor  (r_w[tfca_pkg::TEMP_W-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      case (ch_ff)
         2'd0:    begin lo_byte = lo_col_ff[23:16]; hi_byte = hi_col_ff[23:16]; end
         2'd1:    begin lo_byte = lo_col_ff[15:8];  hi_byte = hi_col_ff[15:8];  end
         default: begin lo_byte = lo_col_ff[7:0];   hi_byte = hi_col_ff[7:0];   end
      endcase
   end

   tfca_lerp u_lerp (
      .lo     (lo_byte),
      .hi     (hi_byte),
      .frac   (frac_ff),
      .result (blend)
   );

   // control, range tracking and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         for (int i = 0; i < tfca_pkg::ENTRIES; i++) begin
            palette_ff[i] <= tfca_pkg::PALETTE_RESET[i];
         end
         act_max_ff    <= tfca_pkg::FIRST_MAX_RESET;
         act_min_ff    <= tfca_pkg::FIRST_MIN_RESET;
         run_max_ff    <= tfca_pkg::RUN_MAX_RESET;
         run_min_ff    <= tfca_pkg::RUN_MIN_RESET;
         count_ff      <= '0;
         frame_done_ff <= 1'b0;
         ch_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_tvalid) begin
            if (csr_index < tfca_pkg::CSR_IDX_W'(tfca_pkg::ENTRIES)) begin
               palette_ff[csr_index] <= csr_data;
            end else if (csr_index == tfca_pkg::REG_FIRST_MAX) begin
               if (!frame_done_ff) act_max_ff <= csr_data[tfca_pkg::TEMP_W-1:0];
            end else if (csr_index == tfca_pkg::REG_FIRST_MIN) begin
               if (!frame_done_ff) act_min_ff <= csr_data[tfca_pkg::TEMP_W-1:0];
            end
         end
         if (rsp_valid_ff && rsp_tready && !send_go) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= need_div ? S_DIV : S_FETCH_LO;
                  if (last) begin
                     act_max_ff    <= run_max_in;
                     act_min_ff    <= run_min_in;
                     run_max_ff    <= tfca_pkg::RUN_MAX_RESET;
                     run_min_ff    <= tfca_pkg::RUN_MIN_RESET;
                     count_ff      <= '0;
                     frame_done_ff <= 1'b1;
                  end else begin
                     run_max_ff <= run_max_in;
                     run_min_ff <= run_min_in;
                     count_ff   <= count_ff + 1'b1;
                  end
               end
            end
            S_DIV: begin
               if (div_done) state_ff <= S_FETCH_LO;
            end
            S_FETCH_LO: state_ff <= S_FETCH_HI;
            S_FETCH_HI: begin
               state_ff <= S_MIX;
               ch_ff    <= '0;
            end
            S_MIX: begin
               ch_ff <= ch_ff + 1'b1;
               if (ch_ff == 2'(tfca_pkg::CHANNELS - 1)) state_ff <= S_SEND;
            end
            S_SEND: begin
               if (send_go) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         lo_idx_ff <= direct_idx;
         hi_idx_ff <= direct_idx;
         frac_ff   <= '0;
         last_ff   <= last;
      end
      if (state_ff == S_DIV && div_done) begin
         lo_idx_ff <= div_lo;
         hi_idx_ff <= div_lo + 1'b1;
         frac_ff   <= quotient[tfca_pkg::FRAC_W-1:0];
      end
      if (state_ff == S_FETCH_LO) lo_col_ff <= palette_ff[lo_idx_ff];
      if (state_ff == S_FETCH_HI) hi_col_ff <= palette_ff[hi_idx_ff];
      if (state_ff == S_MIX) col_ff[ch_ff] <= blend;
      if (send_go) begin
         rsp_data_ff <= {col_ff[2], col_ff[1], col_ff[0]};
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

[sv/tfca_checker.sv]
`default_nettype none
module tfca_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // one item in flight: busy straight after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken again while busy");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind thermal_false_color_autorange_core tfca_checker u_tfca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

[test/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [tfca_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int IDLE_PCT      = 34;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LINES  = 40;

   typedef logic signed [tfca_pkg::TEMP_W-1:0] temp_type;
   typedef struct {
      logic [tfca_pkg::CHAN_W-1:0] red;
      logic [tfca_pkg::CHAN_W-1:0] green;
      logic [tfca_pkg::CHAN_W-1:0] blue;
      logic                        frame_end;
   } colour_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] temperature
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] red, [15:8] green, [23:16] blue
   logic        rsp_tlast;   // frame_end
   logic        csr_tvalid;
   logic        csr_tready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   // colour mapping state
   logic [tfca_pkg::COLOUR_W-1:0] pal [tfca_pkg::ENTRIES];
   temp_type                      first_max, first_min;
   temp_type                      act_max, act_min;
   temp_type                      run_max, run_min;
   int unsigned                   pix_count;
   bit                            first_done;

   colour_type  pending_colours [$];
   int unsigned errors;
   int unsigned cycles;
   int          idle_pct = IDLE_PCT;

   thermal_false_color_autorange_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (errors < REPORT_LINES)
         $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
      errors++;
   endtask

   function automatic logic [tfca_pkg::CHAN_W-1:0] blend(
         logic [tfca_pkg::CHAN_W-1:0] a, logic [tfca_pkg::CHAN_W-1:0] b, int unsigned f);
      int unsigned mix;
      mix = a * ((1 << tfca_pkg::FRAC_W) - f) + b * f;
      return tfca_pkg::CHAN_W'(mix >> tfca_pkg::FRAC_W);
   endfunction

   task automatic predict_colour(temp_type t);
      int          d, r, lo_i, hi_i;
      int unsigned pos, f;
      colour_type  c;
      d = int'(t) - int'(act_min);
      r = int'(act_max) - int'(act_min);
      f = 0;
      if (r <= 0) begin
         lo_i = (d > 0) ? tfca_pkg::ENTRY_TOP : tfca_pkg::ENTRY_BOTTOM;
         hi_i = lo_i;
      end else if (d <= 0) begin
         lo_i = tfca_pkg::ENTRY_BOTTOM;
         hi_i = lo_i;
      end else if (d >= r) begin
         lo_i = tfca_pkg::ENTRY_TOP;
         hi_i = lo_i;
      end else begin
         pos  = (d << tfca_pkg::QUO_W) / r;
         lo_i = pos >> tfca_pkg::FRAC_W;
         hi_i = lo_i + 1;
         f    = pos % (1 << tfca_pkg::FRAC_W);
      end
      c.red   = blend(pal[lo_i][23:16], pal[hi_i][23:16], f);
      c.green = blend(pal[lo_i][15:8],  pal[hi_i][15:8],  f);
      c.blue  = blend(pal[lo_i][7:0],   pal[hi_i][7:0],   f);
      if (t > run_max)
         run_max = t;
      if (t < run_min)
         run_min = t;
      pix_count++;
      c.frame_end = (pix_count >= tfca_pkg::FRAME_PIXELS);
      if (c.frame_end) begin
         // colour above still used the old range
         act_max    = run_max;
         act_min    = run_min;
         run_max    = tfca_pkg::RUN_MAX_RESET;
         run_min    = tfca_pkg::RUN_MIN_RESET;
         pix_count  = 0;
         first_done = 1'b1;
      end
      pending_colours.push_back(c);
   endtask

   always @(posedge clock) begin
      colour_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_colours.size() == 0) begin
            report_mismatch("unexpected item", {rsp_tlast, rsp_tdata}, 0);
         end else begin
            want = pending_colours.pop_front();
            if (rsp_tdata[7:0] !== want.red)
               report_mismatch("red", rsp_tdata[7:0], want.red);
            if (rsp_tdata[15:8] !== want.green)
               report_mismatch("green", rsp_tdata[15:8], want.green);
            if (rsp_tdata[23:16] !== want.blue)
               report_mismatch("blue", rsp_tdata[23:16], want.blue);
            if (rsp_tlast !== want.frame_end)
               report_mismatch("frame_end", rsp_tlast, want.frame_end);
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   task automatic send_pixel(temp_type t);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_colour(t);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_colours.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [tfca_pkg::CSR_IDX_W-1:0] idx,
                            logic [tfca_pkg::COLOUR_W-1:0] value);
      csr_tvalid <= 1'b1;
      csr_index  <= idx;
      csr_data   <= value;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
      if (idx < tfca_pkg::ENTRIES) begin
         pal[idx] = value;
      end else if (idx == tfca_pkg::REG_FIRST_MAX) begin
         first_max = value[tfca_pkg::TEMP_W-1:0];
         if (!first_done)
            act_max = first_max;
      end else if (idx == tfca_pkg::REG_FIRST_MIN) begin
         first_min = value[tfca_pkg::TEMP_W-1:0];
         if (!first_done)
            act_min = first_min;
      end
      @(posedge clock);
   endtask

   // upper data bits are don't-care for the range registers
   task automatic write_first_range(temp_type hi, temp_type lo);
      write_reg(tfca_pkg::REG_FIRST_MAX, {8'($urandom), hi});
      write_reg(tfca_pkg::REG_FIRST_MIN, {8'($urandom), lo});
   endtask

   task automatic randomise_palette();
      for (int i = 0; i < tfca_pkg::ENTRIES; i++)
         write_reg(tfca_pkg::CSR_IDX_W'(i), tfca_pkg::COLOUR_W'($urandom));
   endtask

   function automatic temp_type pick_temperature(int lo, int hi, bit wild);
      int k;
      k = $urandom_range(99);
      if (wild && k < 15)
         return temp_type'($urandom);
      if (k < 30)
         return temp_type'(($urandom_range(1) ? lo : hi) + int'($urandom_range(4)) - 2);
      return temp_type'(lo + int'($urandom_range(hi - lo)));
   endfunction

   task automatic test_reset_range();
      int pts [$] = '{-32768, 32767, 0, 800, 1, 799, 200, 400, 600, -1};
      foreach (pts[i])
         send_pixel(temp_type'(pts[i]));
   endtask

   task automatic test_palette_extremes();
      int pts [$] = '{100, 300, 500, 700, 250};
      logic [tfca_pkg::COLOUR_W-1:0] cols [tfca_pkg::ENTRIES] = '{
         24'h000000, 24'hffffff, 24'h000000, 24'hffffff, 24'h5a5a5a
      };
      wait_idle();
      for (int i = 0; i < tfca_pkg::ENTRIES; i++)
         write_reg(tfca_pkg::CSR_IDX_W'(i), cols[i]);
      foreach (pts[i])
         send_pixel(temp_type'(pts[i]));
   endtask

   task automatic test_flat_range();
      wait_idle();
      write_first_range(100, 100);
      send_pixel(100);
      send_pixel(101);
      send_pixel(99);
      wait_idle();
      write_first_range(-5, 10);
      send_pixel(11);
      send_pixel(10);
      send_pixel(-32768);
   endtask

   task automatic test_full_span();
      int pts [$] = '{-32768, 32767, 0, -1, 12345, -20000};
      wait_idle();
      randomise_palette();
      write_first_range(32767, -32768);
      write_reg(REG_UNUSED, tfca_pkg::COLOUR_W'($urandom));
      foreach (pts[i])
         send_pixel(temp_type'(pts[i]));
   endtask

   task automatic test_first_frame();
      wait_idle();
      randomise_palette();
      write_first_range(1200, -400);
      do
         send_pixel(pick_temperature(-400, 1200, 1'b1));
      while (pix_count != 0);
   endtask

   // range registers no longer reach the active range; first stretch runs without gaps
   task automatic test_frozen_first_range();
      wait_idle();
      write_first_range(300, 200);
      for (int i = 0; i < tfca_pkg::ENTRIES; i++)
         write_reg(tfca_pkg::CSR_IDX_W'(i), tfca_pkg::PALETTE_RESET[i]);
      idle_pct = 0;
      for (int n = 0; n < 60; n++) begin
         send_pixel(pick_temperature(-500, 1500, 1'b0));
         if (n == 40)
            idle_pct = IDLE_PCT;
      end
      idle_pct = IDLE_PCT;
   endtask

   task automatic test_narrow_range();
      wait_idle();
      randomise_palette();
      repeat (40)
         send_pixel(pick_temperature(-500, 1500, 1'b0));
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_tvalid <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      errors = 0;
      for (int i = 0; i < tfca_pkg::ENTRIES; i++)
         pal[i] = tfca_pkg::PALETTE_RESET[i];
      first_max  = tfca_pkg::FIRST_MAX_RESET;
      first_min  = tfca_pkg::FIRST_MIN_RESET;
      act_max    = first_max;
      act_min    = first_min;
      run_max    = tfca_pkg::RUN_MAX_RESET;
      run_min    = tfca_pkg::RUN_MIN_RESET;
      pix_count  = 0;
      first_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_range();
      test_palette_extremes();
      test_flat_range();
      test_full_span();
      test_first_frame();
      test_frozen_first_range();
      test_narrow_range();

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
